### sv/mts_pkg.sv
package mts_pkg;

    // default sizes of the melody tables
    localparam int MAX_SONGS_DEF = 16;
    localparam int MAX_NOTES_DEF = 256;

    // song index is 4 bits wide, so never more than 16 songs in rotation
    localparam int SONG_LIMIT = 16;

    localparam logic signed [7:0] TEMPO_MIN = -8'sd75;
    localparam logic signed [7:0] TEMPO_MAX = 8'sd75;
    localparam logic [7:0]        PCT_FULL  = 8'd100;

    // x / 100 == (x * ceil(2^31 / 100)) >> 31, exact for x < 2^24
    localparam int          DIV_SHIFT    = 31;
    localparam logic [24:0] DIV100_RECIP = 25'd21474837;

    // op codes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_PLAY      = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_NEXT      = 3'd3;
    localparam logic [2:0] OP_PREV      = 3'd4;
    localparam logic [2:0] OP_LOAD_NOTE = 3'd5;
    localparam logic [2:0] OP_SET_LEN   = 3'd6;

    // register indexes
    localparam logic [1:0] REG_SONG_COUNT = 2'd0;
    localparam logic [1:0] REG_TEMPO      = 2'd1;
    localparam logic [1:0] REG_MUTE       = 2'd2;

    // note events
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_NOTE = 2'd1;
    localparam logic [1:0] EV_SONG = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  song_sel;
        logic [7:0]  element_sel;
        logic [15:0] note_freq;
        logic [15:0] note_duration;
        logic [7:0]  song_len;
    } t_in;

    typedef struct packed {
        logic [15:0] tone_freq;
        logic        tone_on;
        logic [1:0]  note_event;
        logic        is_playing;
        logic [3:0]  song_index;
        logic [7:0]  element_index;
    } t_out;

    typedef struct packed {
        logic [1:0] reg_idx;
        logic [7:0] wdata;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic exec;  // item transfer: update sequencer state, write tables
        logic rd;    // read note tables at current position
        logic mul;   // duration times tempo factor
        logic fin;   // scale, load result register
    } t_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_sts;

endpackage

### sv/mts_stream_if.sv
interface mts_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/mts_ctrl.sv
module mts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mts_pkg::t_sts i_sts,
    output mts_pkg::t_cmd o_cmd
);

    mts_pkg::t_state r_state;
    mts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mts_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = mts_pkg::S_READ;
                end
            end
            mts_pkg::S_READ: n_state = mts_pkg::S_MUL;
            mts_pkg::S_MUL:  n_state = mts_pkg::S_DONE;
            mts_pkg::S_DONE: begin
                if (!i_sts.out_blocked) begin
                    n_state = mts_pkg::S_IDLE;
                end
            end
            default: n_state = mts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            mts_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.exec = i_in_valid;
            end
            mts_pkg::S_READ: o_cmd.rd  = 1'b1;
            mts_pkg::S_MUL:  o_cmd.mul = 1'b1;
            mts_pkg::S_DONE: o_cmd.fin = !i_sts.out_blocked;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### sv/mts_dp.sv
module mts_dp #(
    parameter int MAX_SONGS = mts_pkg::MAX_SONGS_DEF,
    parameter int MAX_NOTES = mts_pkg::MAX_NOTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mts_pkg::t_cmd i_cmd,
    output mts_pkg::t_sts o_sts,
    input  mts_pkg::t_in  i_in,
    input  logic          i_cfg_valid,
    input  mts_pkg::t_cfg i_cfg,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mts_pkg::t_out o_out
);

    localparam int SW    = (MAX_SONGS > 1) ? $clog2(MAX_SONGS) : 1;
    localparam int NW    = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int AW    = SW + NW;
    localparam int DEPTH = 2 ** AW;
    localparam int LIM   = (MAX_SONGS < mts_pkg::SONG_LIMIT) ? MAX_SONGS
                                                            : mts_pkg::SONG_LIMIT;
    localparam logic [4:0] LIM5   = 5'(LIM);
    localparam logic [8:0] SONGS9 = 9'(MAX_SONGS);
    localparam logic [8:0] NOTES9 = 9'(MAX_NOTES);

    // configuration
    logic [4:0]        r_song_count;
    logic signed [7:0] r_tempo;
    logic              r_mute;

    // sequencer state
    logic [3:0]  r_song,    n_song;
    logic [7:0]  r_elem,    n_elem;
    logic [15:0] r_elapsed, n_elapsed;
    logic        r_run,     n_run;
    logic [15:0] r_dur;
    logic        r_restart, n_restart;
    logic [1:0]  r_event,   n_event;

    // tables
    logic [15:0] r_mem_freq [DEPTH];
    logic [15:0] r_mem_dur  [DEPTH];
    logic [7:0]  r_len      [MAX_SONGS];

    // read / scale pipeline
    logic [15:0] r_freq_rd;
    logic [15:0] r_dur_rd;
    logic        r_rd_ok;
    logic [15:0] r_freq_cap;
    logic [23:0] r_prod;

    logic              r_out_valid;
    mts_pkg::t_out     r_out;

    logic signed [7:0] cfg_tempo;
    logic [4:0]        cnt;
    logic [7:0]        cur_song8;
    logic [7:0]        sel_song8;
    logic              song_ok;
    logic [7:0]        cur_len;
    logic [15:0]       el_sat;
    logic [8:0]        e9;
    logic [4:0]        nxt5;
    logic [3:0]        adv_song;
    logic [4:0]        prv5;
    logic [3:0]        prev_song;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic              load_ok;
    logic signed [8:0] fac9;
    logic [7:0]        factor;
    logic [15:0]       dur_eff;
    logic [23:0]       prod;
    logic [48:0]       q49;
    logic [17:0]       quot;
    logic [15:0]       scaled;

    assign cfg_tempo = signed'(i_cfg.wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_song_count <= 5'd1;
            r_tempo      <= '0;
            r_mute       <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg.reg_idx)
                mts_pkg::REG_SONG_COUNT: r_song_count <= i_cfg.wdata[4:0];
                mts_pkg::REG_TEMPO: begin
                    if (cfg_tempo >= mts_pkg::TEMPO_MIN &&
                        cfg_tempo <= mts_pkg::TEMPO_MAX) begin
                        r_tempo <= cfg_tempo;
                    end
                end
                mts_pkg::REG_MUTE: r_mute <= i_cfg.wdata[0];
                default: begin
                    r_mute <= r_mute;
                end
            endcase
        end
    end

    // songs in rotation, clamped to 1..LIM
    assign cnt = (r_song_count == 5'd0) ? 5'd1 :
                 (r_song_count > LIM5)  ? LIM5 : r_song_count;

    assign cur_song8 = {4'b0, r_song};
    assign sel_song8 = {4'b0, i_in.song_sel};
    assign song_ok   = {1'b0, cur_song8} < SONGS9;
    assign cur_len   = song_ok ? r_len[cur_song8[SW-1:0]] : 8'd0;

    assign el_sat   = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
    assign e9       = {1'b0, r_elem} + 9'd1;
    assign nxt5     = {1'b0, r_song} + 5'd1;
    assign adv_song = (nxt5 >= cnt) ? 4'd0 : nxt5[3:0];

    always_comb begin
        prv5 = (r_song == 4'd0) ? cnt - 5'd1 : {1'b0, r_song} - 5'd1;
        if (prv5 >= cnt) begin
            prv5 = cnt - 5'd1;
        end
        prev_song = prv5[3:0];
    end

    always_comb begin
        n_song    = r_song;
        n_elem    = r_elem;
        n_elapsed = r_elapsed;
        n_run     = r_run;
        n_restart = 1'b0;
        n_event   = mts_pkg::EV_NONE;
        case (i_in.op)
            mts_pkg::OP_TICK: begin
                if (r_run) begin
                    n_elapsed = el_sat;
                    if (el_sat >= r_dur) begin
                        if (e9 >= {1'b0, cur_len}) begin
                            n_song    = adv_song;
                            n_elem    = '0;
                            n_elapsed = '0;
                            n_restart = 1'b1;
                            n_event   = mts_pkg::EV_SONG;
                        end else begin
                            n_elem    = e9[7:0];
                            n_elapsed = '0;
                            n_restart = 1'b1;
                            n_event   = mts_pkg::EV_NOTE;
                        end
                    end
                end
            end
            mts_pkg::OP_PLAY, mts_pkg::OP_NEXT, mts_pkg::OP_PREV: begin
                n_song    = (i_in.op == mts_pkg::OP_PLAY) ? 4'd0 :
                            (i_in.op == mts_pkg::OP_NEXT) ? adv_song : prev_song;
                n_elem    = '0;
                n_elapsed = '0;
                n_run     = 1'b1;
                n_restart = 1'b1;
            end
            mts_pkg::OP_STOP: begin
                n_elem = '0;
                n_run  = 1'b0;
            end
            default: begin
                n_run = r_run;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_song    <= '0;
            r_elem    <= '0;
            r_elapsed <= '0;
            r_run     <= 1'b0;
        end else if (i_cmd.exec) begin
            r_song    <= n_song;
            r_elem    <= n_elem;
            r_elapsed <= n_elapsed;
            r_run     <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_restart <= n_restart;
            r_event   <= n_event;
        end
    end

    // table writes
    assign waddr   = {sel_song8[SW-1:0], i_in.element_sel[NW-1:0]};
    assign load_ok = ({1'b0, sel_song8} < SONGS9) &&
                     ({1'b0, i_in.element_sel} < NOTES9);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && i_in.op == mts_pkg::OP_LOAD_NOTE && load_ok) begin
            r_mem_freq[waddr] <= i_in.note_freq;
            r_mem_dur[waddr]  <= i_in.note_duration;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && i_in.op == mts_pkg::OP_SET_LEN &&
            {1'b0, sel_song8} < SONGS9) begin
            r_len[sel_song8[SW-1:0]] <= i_in.song_len;
        end
    end

    // table reads at the position left by the item
    assign raddr = {cur_song8[SW-1:0], r_elem[NW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_freq_rd <= r_mem_freq[raddr];
            r_dur_rd  <= r_mem_dur[raddr];
            r_rd_ok   <= song_ok && ({1'b0, r_elem} < NOTES9);
        end
    end

    // factor = 100 - tempo, 25..175
    assign fac9    = $signed({1'b0, mts_pkg::PCT_FULL}) - $signed({r_tempo[7], r_tempo});
    assign factor  = fac9[7:0];
    assign dur_eff = r_rd_ok ? r_dur_rd : 16'd0;
    assign prod    = 24'(dur_eff) * 24'(factor);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod     <= prod;
            r_freq_cap <= r_rd_ok ? r_freq_rd : 16'd0;
        end
    end

    assign q49    = 49'(r_prod) * 49'(mts_pkg::DIV100_RECIP);
    assign quot   = q49[mts_pkg::DIV_SHIFT +: 18];
    assign scaled = (quot[17:16] != 2'b00) ? 16'hFFFF : quot[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= '0;
        end else if (i_cmd.fin && r_restart) begin
            r_dur <= scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out.tone_freq     <= r_run ? r_freq_cap : 16'd0;
            r_out.tone_on       <= r_run && !r_mute;
            r_out.note_event    <= r_event;
            r_out.is_playing    <= r_run;
            r_out.song_index    <= r_song;
            r_out.element_index <= r_elem;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;
    assign o_sts.out_blocked = r_out_valid && !i_out_ready;

endmodule

### sv/melody_tone_sequencer_top.sv
// Channel   Dir  Payload                                  Transfer
// i_in      in   op, song_sel, element_sel, note_freq,    valid & ready
//                note_duration, song_len
// o_out     out  tone_freq, tone_on, note_event,          valid & ready
//                is_playing, song_index, element_index
// i_cfg     in   reg_idx (0 count, 1 tempo, 2 mute),      valid & ready (ready tied high)
//                wdata
//
// One item at a time passes in order through: transfer and state update, note table read,
// duration x tempo multiply, divide-by-100 multiply and result load.
// The result register sits after that; a new item is taken while it still
// waits, and only the final step stalls when it is still occupied.
// Reset (i_rst_n low, synchronous) stops playback at song 0, note 0,
// song count 1, tempo 0, unmuted. Note and length tables are not cleared.
module melody_tone_sequencer_top #(
    parameter int MAX_SONGS = mts_pkg::MAX_SONGS_DEF,
    parameter int MAX_NOTES = mts_pkg::MAX_NOTES_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    mts_stream_if.sink   i_in,
    mts_stream_if.source o_out,
    mts_stream_if.sink   i_cfg
);

    mts_pkg::t_cmd cmd;
    mts_pkg::t_sts sts;

    // registers are plain flops, every write is taken at once
    assign i_cfg.ready = 1'b1;

    // sequencing control: one item in flight
    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // tables, position state, tempo scaling and result register
    mts_dp #(
        .MAX_SONGS (MAX_SONGS),
        .MAX_NOTES (MAX_NOTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg       (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out       (o_out.data)
    );

endmodule

### sv/mts_checker.sv
module mts_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input mts_pkg::t_out i_out_data
);

    // result register empties on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // one item at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in flight");

    // stopped: silent, position at note 0
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.is_playing |->
            i_out_data.tone_freq == 16'd0 && !i_out_data.tone_on &&
            i_out_data.element_index == 8'd0)
        else $error("tone or position while stopped");

    // a song change lands on note 0 and plays
    a_song_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.note_event == mts_pkg::EV_SONG |->
            i_out_data.element_index == 8'd0 && i_out_data.is_playing)
        else $error("song change not at note 0");

endmodule

bind melody_tone_sequencer_top mts_checker u_mts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
